/* rtl/core/pbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, constants and helpers of the planar PackBits row decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

	// Field widths
	localparam int unsigned CFG_W      = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CH_W       = 3;
	localparam int unsigned LANE_W     = 2;
	localparam int unsigned ROW_W      = 12;
	localparam int unsigned COL_W      = 13;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 48;

	// Default for the dimension limit
	localparam int unsigned MAX_DIM_DEFAULT = 4096;

	// Row count limit that the row index can hold
	localparam logic [CFG_W-1:0] ROW_CAP = 13'd4096;

	// Plane count limit
	localparam logic [CH_W-1:0] CH_MAX = 3'd5;

	// Header codes
	localparam logic [BYTE_W-1:0] HDR_NOP     = 8'h80;
	localparam logic [8:0]        REPEAT_BASE = 9'd257;

	// Input word kinds
	localparam logic MODE_ROW  = 1'b0;
	localparam logic MODE_BYTE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

	// ARGB lanes
	localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd0;
	localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
	localparam logic [LANE_W-1:0] LANE_RED   = 2'd2;
	localparam logic [LANE_W-1:0] LANE_ALPHA = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
		logic [CH_W-1:0]  channel_count;
	} cfg_t;

	typedef struct packed {
		logic               row_started;
		logic [COUNT_W-1:0] row_bytes_left;
		logic [LEN_W-1:0]   literal_left;
		logic               repeat_pending;
		logic [LEN_W-1:0]   repeat_length;
		logic [ROW_W-1:0]   current_row;
		logic [CH_W-1:0]    current_channel;
		logic [COL_W-1:0]   current_column;
	} state_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel_index;
		logic [LANE_W-1:0] byte_lane;
		logic [ROW_W-1:0]  row_index;
		logic [ROW_W-1:0]  start_column;
		logic [BYTE_W-1:0] pixel_value;
		logic [LEN_W-1:0]  run_length;
		logic              row_done;
		logic              error_flag;
	} result_t;

	// Plane to ARGB lane
	function automatic logic [LANE_W-1:0] lane_of(input logic [CH_W-1:0] ch);
		logic [LANE_W-1:0] lane;
		case (ch)
			3'd0:    lane = LANE_RED;
			3'd1:    lane = LANE_GREEN;
			3'd2:    lane = LANE_BLUE;
			default: lane = LANE_ALPHA;
		endcase
		return lane;
	endfunction

endpackage

/* rtl/core/pbd_step.sv */
// ----------------------------------------------------------------------------
// pbd_step
// Next-state and result logic for one input word of the PackBits decoder.
// ----------------------------------------------------------------------------
module pbd_step #(
	parameter int unsigned MAX_DIM = pbd_pkg::MAX_DIM_DEFAULT
) (
	input  pbd_pkg::cfg_t                      cfg,
	input  pbd_pkg::state_t                    st,
	input  logic                               mode,
	input  logic [pbd_pkg::IN_DATA_W-1:0]      value,
	output pbd_pkg::state_t                    nxt,
	output logic                               emit,
	output pbd_pkg::result_t                   res
);

	logic [pbd_pkg::CFG_W-1:0]   eff_w;
	logic [pbd_pkg::CFG_W-1:0]   h_lim;
	logic [pbd_pkg::CFG_W-1:0]   eff_h;
	logic [pbd_pkg::CH_W-1:0]    eff_ch;
	logic [pbd_pkg::CFG_W-1:0]   next_row;
	logic [pbd_pkg::CH_W-1:0]    next_ch;
	logic [pbd_pkg::BYTE_W-1:0]  byte_v;
	logic [pbd_pkg::COUNT_W-1:0] bytes_dec;
	logic [pbd_pkg::LEN_W-1:0]   lit_dec;
	logic                        done;
	logic                        err_in;
	logic [pbd_pkg::LEN_W-1:0]   want;
	logic [pbd_pkg::COL_W-1:0]   start;
	logic [pbd_pkg::COL_W-1:0]   room;
	logic [pbd_pkg::LEN_W-1:0]   len;
	logic                        err;
	logic [8:0]                  rep_len;

	// Effective dimensions after clamping
	always_comb begin
		if (32'(cfg.image_width) < 32'(MAX_DIM)) begin
			eff_w = cfg.image_width;
		end else begin
			eff_w = pbd_pkg::CFG_W'(MAX_DIM);
		end
		if (32'(cfg.image_height) < 32'(MAX_DIM)) begin
			h_lim = cfg.image_height;
		end else begin
			h_lim = pbd_pkg::CFG_W'(MAX_DIM);
		end
		if (h_lim > pbd_pkg::ROW_CAP) begin
			eff_h = pbd_pkg::ROW_CAP;
		end else if (h_lim == '0) begin
			eff_h = pbd_pkg::CFG_W'(1);
		end else begin
			eff_h = h_lim;
		end
		if (cfg.channel_count == '0) begin
			eff_ch = pbd_pkg::CH_W'(1);
		end else if (cfg.channel_count > pbd_pkg::CH_MAX) begin
			eff_ch = pbd_pkg::CH_MAX;
		end else begin
			eff_ch = cfg.channel_count;
		end
	end

	// Decode one word
	always_comb begin
		nxt       = st;
		emit      = 1'b0;
		done      = 1'b0;
		err_in    = 1'b0;
		want      = '0;
		byte_v    = value[pbd_pkg::BYTE_W-1:0];
		bytes_dec = st.row_bytes_left - pbd_pkg::COUNT_W'(1);
		lit_dec   = st.literal_left - pbd_pkg::LEN_W'(1);
		next_row  = {1'b0, st.current_row} + pbd_pkg::CFG_W'(1);
		next_ch   = st.current_channel + pbd_pkg::CH_W'(1);
		rep_len   = pbd_pkg::REPEAT_BASE - {1'b0, byte_v};

		if (mode == pbd_pkg::MODE_ROW) begin
			// Open the next row, dropping any unfinished run
			nxt.row_started = 1'b1;
			if (!st.row_started) begin
				nxt.current_row     = '0;
				nxt.current_channel = '0;
			end else if (next_row >= eff_h) begin
				nxt.current_row     = '0;
				nxt.current_channel = (next_ch >= eff_ch) ? '0 : next_ch;
			end else begin
				nxt.current_row = next_row[pbd_pkg::ROW_W-1:0];
			end
			nxt.row_bytes_left = value;
			nxt.literal_left   = '0;
			nxt.repeat_pending = 1'b0;
			nxt.repeat_length  = '0;
			nxt.current_column = '0;
		end else if (st.row_started && st.row_bytes_left != '0) begin
			nxt.row_bytes_left = bytes_dec;
			done = (bytes_dec == '0);
			if (st.repeat_pending) begin
				// Value byte of a repeat run
				nxt.repeat_pending = 1'b0;
				nxt.repeat_length  = '0;
				emit = 1'b1;
				want = st.repeat_length;
			end else if (st.literal_left != '0) begin
				// Literal byte; cut short if the row ends early
				nxt.literal_left = done ? '0 : lit_dec;
				emit   = 1'b1;
				want   = pbd_pkg::LEN_W'(1);
				err_in = done && (lit_dec != '0);
			end else begin
				// Header byte
				if (!byte_v[pbd_pkg::BYTE_W-1]) begin
					nxt.literal_left = byte_v + pbd_pkg::LEN_W'(1);
				end else if (byte_v != pbd_pkg::HDR_NOP) begin
					nxt.repeat_pending = 1'b1;
					nxt.repeat_length  = rep_len[pbd_pkg::LEN_W-1:0];
				end
				if (done) begin
					nxt.literal_left   = '0;
					nxt.repeat_pending = 1'b0;
					nxt.repeat_length  = '0;
				end
			end
		end

		// Fit the run into the columns left
		start = st.current_column;
		room  = eff_w - start;
		err   = err_in;
		if (start >= eff_w) begin
			len = '0;
			err = 1'b1;
		end else if ({5'b0, want} < room) begin
			len = want;
		end else begin
			len = room[pbd_pkg::LEN_W-1:0];
		end
		if ({5'b0, len} < {5'b0, want}) begin
			err = 1'b1;
		end
		if (emit) begin
			nxt.current_column = start + pbd_pkg::COL_W'(len);
		end

		res.channel_index = st.current_channel;
		res.byte_lane     = pbd_pkg::lane_of(st.current_channel);
		res.row_index     = st.current_row;
		res.start_column  = start[pbd_pkg::ROW_W-1:0];
		res.pixel_value   = byte_v;
		res.run_length    = len;
		res.row_done      = done;
		res.error_flag    = err;
	end

endmodule

/* rtl/core/packbits_plane_row_decoder.sv */
// ----------------------------------------------------------------------------
// packbits_plane_row_decoder
// Planar PackBits row decoder: row-start and compressed byte words in,
// one literal byte or repeat run per result word out.
// ----------------------------------------------------------------------------
// The decoder takes one input word per clock and gives at most one result
// word per input word. A word is latched into an input register, decoded by
// the step logic against the run and row counters in the same cycle, and its
// result lands in an output register. The throughput of one word per cycle is
// set by the single counter update per word; the input stalls only when a
// result is held in the output register and the sink is not ready. The user
// must write configuration through cfg_we/cfg_index/cfg_data only while no
// word is in flight; the block itself does not enforce this.
module packbits_plane_row_decoder #(
	parameter int unsigned MAX_DIM = pbd_pkg::MAX_DIM_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration
	input  logic                               cfg_we,
	input  logic [pbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pbd_pkg::CFG_W-1:0]          cfg_data,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pbd_pkg::IN_DATA_W-1:0]      s_tdata,   // value[15:0]
	input  logic                               s_tuser,   // mode
	// Output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// channel_index[2:0], byte_lane[4:3], row_index[16:5], start_column[28:17],
	// pixel_value[36:29], run_length[44:37], zero fill[47:45]
	output logic [pbd_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast,   // row_done
	output logic                               m_tuser    // error_flag
);

	pbd_pkg::cfg_t    cfg_q;
	pbd_pkg::state_t  st_q;
	pbd_pkg::state_t  st_nxt;
	pbd_pkg::result_t res;
	pbd_pkg::result_t res_q;
	logic                              emit;
	logic                              in_valid_s1;
	logic                              mode_s1;
	logic [pbd_pkg::IN_DATA_W-1:0]     value_s1;
	logic                              out_valid_q;
	logic                              out_free;
	logic                              advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= pbd_pkg::CFG_W'(1);
			cfg_q.image_height  <= pbd_pkg::CFG_W'(1);
			cfg_q.channel_count <= pbd_pkg::CH_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				pbd_pkg::REG_WIDTH:    cfg_q.image_width   <= cfg_data;
				pbd_pkg::REG_HEIGHT:   cfg_q.image_height  <= cfg_data;
				pbd_pkg::REG_CHANNELS: cfg_q.channel_count <= cfg_data[pbd_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: a word moves on unless its result meets a full output
	assign out_free = !out_valid_q || m_tready;
	assign advance  = in_valid_s1 && (out_free || !emit);
	assign s_tready = !in_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1  <= s_tuser;
			value_s1 <= s_tdata;
		end
	end

	// Decode logic
	pbd_step #(
		.MAX_DIM(MAX_DIM)
	) u_step (
		.cfg   (cfg_q),
		.st    (st_q),
		.mode  (mode_s1),
		.value (value_s1),
		.nxt   (st_nxt),
		.emit  (emit),
		.res   (res)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.row_started     <= 1'b0;
			st_q.row_bytes_left  <= '0;
			st_q.literal_left    <= '0;
			st_q.repeat_pending  <= 1'b0;
			st_q.repeat_length   <= '0;
			st_q.current_row     <= '1;
			st_q.current_channel <= '0;
			st_q.current_column  <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q.run_length, res_q.pixel_value, res_q.start_column,
		res_q.row_index, res_q.byte_lane, res_q.channel_index};
	assign m_tlast  = res_q.row_done;
	assign m_tuser  = res_q.error_flag;

endmodule
